/* rtl/first_fit_range_allocator_defines.svh */
`ifndef FIRST_FIT_RANGE_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_RANGE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define FFRA_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("ffra check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define FFRA_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("ffra check failed");

`endif

/* rtl/ffra_pkg.sv */
`timescale 1ns / 1ps
package ffra_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int DATA_W = 32;
	localparam int TOTAL_W = 38;
	localparam int CAND_W = DATA_W + 2;
	localparam int END_W = DATA_W + 3;

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);
	localparam logic [CAND_W-1:0] GAP_BYTES = CAND_W'(34'h1000);
	localparam logic [DATA_W-1:0] CHUNK_RESET = 32'h1000_0000;

	localparam logic [1:0] FN_FIND = 2'd0;
	localparam logic [1:0] FN_BIND = 2'd1;
	localparam logic [1:0] FN_FREE = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_NOMATCH = 2'd3;

	typedef struct packed {
		logic [DATA_W-1:0] start;
		logic [DATA_W-1:0] len;
	} entry_t;

	typedef struct packed {
		logic we;
		logic [IDX_W-1:0] waddr;
		entry_t wdata;
		logic [IDX_W-1:0] raddr;
	} tbl_req_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_BOUND,
		S_SCAN,
		S_NEXT,
		S_CALC,
		S_FSCAN,
		S_SHIFT,
		S_RESULT
	} state_t;

	typedef enum logic [1:0] {
		PH_ZERO,
		PH_LAST,
		PH_EACH
	} phase_t;

endpackage

/* rtl/ffra_table.sv */
`timescale 1ns / 1ps
module ffra_table
	import ffra_pkg::*;
(
	input logic clk,
	input tbl_req_t req,
	output entry_t rd_data
);

	entry_t mem [MAX_ENTRIES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[req.raddr];
	end

endmodule

/* rtl/ffra_olap.sv */
`timescale 1ns / 1ps
module ffra_olap
	import ffra_pkg::*;
(
	input logic [DATA_W-1:0] pos,
	input logic [DATA_W-1:0] last,
	input entry_t ent,
	output logic hit
);

	logic [DATA_W:0] s;
	logic [DATA_W:0] e;
	logic [DATA_W:0] p;
	logic [DATA_W:0] q;

	// Bounds are inclusive on both ends.
	always_comb begin
		s = {1'b0, ent.start};
		e = {1'b0, ent.start} + {1'b0, ent.len};
		p = {1'b0, pos};
		q = {1'b0, last};
		hit = (p >= s && p <= e) || (q >= s && q <= e) || (p <= s && q >= e);
	end

endmodule

/* rtl/ffra_seq.sv */
`timescale 1ns / 1ps
module ffra_seq
	import ffra_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] func,
	input logic [DATA_W-1:0] size,
	input logic [DATA_W-1:0] offset,
	input logic [DATA_W-1:0] chunk_size,
	output tbl_req_t req,
	input entry_t rd_data,
	output logic out_valid,
	input logic out_stall,
	output logic [1:0] status,
	output logic [DATA_W-1:0] offset_found,
	output logic [TOTAL_W-1:0] total_allocated
);

	state_t state_q, state_d;
	phase_t phase_q, phase_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [TOTAL_W-1:0] total_q, total_d;
	logic out_valid_q, out_valid_d;

	logic [DATA_W-1:0] size_q, size_d;
	logic [DATA_W-1:0] offset_q, offset_d;
	logic [CAND_W-1:0] cand_q, cand_d;
	logic [DATA_W-1:0] pos_q, pos_d;
	logic [DATA_W-1:0] end_q, end_d;
	logic [IDX_W-1:0] cidx_q, cidx_d;
	logic [IDX_W-1:0] sidx_q, sidx_d;
	logic [1:0] res_status_q, res_status_d;
	logic [DATA_W-1:0] res_off_q, res_off_d;
	logic [1:0] out_status_q, out_status_d;
	logic [DATA_W-1:0] out_off_q, out_off_d;
	logic [TOTAL_W-1:0] out_total_q, out_total_d;

	logic hit;
	logic [END_W-1:0] end_sum;
	logic [CNT_W-1:0] cnt_m1;
	logic scan_last;
	logic cand_last;
	logic shift_last;
	logic match;

	ffra_olap u_olap (
		.pos(pos_q),
		.last(end_q),
		.ent(rd_data),
		.hit(hit)
	);

	always_comb begin
		end_sum = END_W'(cand_q) + END_W'(size_q);
		cnt_m1 = cnt_q - CNT_W'(1);
		scan_last = ({1'b0, sidx_q} == cnt_m1);
		cand_last = ({1'b0, cidx_q} == cnt_m1);
		shift_last = ({1'b0, sidx_q} + CNT_W'(1) == cnt_q);
		match = (rd_data.start == offset_q) && (rd_data.len == size_q);

		state_d = state_q;
		phase_d = phase_q;
		cnt_d = cnt_q;
		total_d = total_q;
		size_d = size_q;
		offset_d = offset_q;
		cand_d = cand_q;
		pos_d = pos_q;
		end_d = end_q;
		cidx_d = cidx_q;
		sidx_d = sidx_q;
		res_status_d = res_status_q;
		res_off_d = res_off_q;
		out_status_d = out_status_q;
		out_off_d = out_off_q;
		out_total_d = out_total_q;
		out_valid_d = out_valid_q && out_stall;
		req = '0;
		in_stall = (state_q != S_IDLE);

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					size_d = size;
					offset_d = offset;
					res_status_d = ST_OK;
					res_off_d = '0;
					state_d = S_RESULT;
					case (func)
						FN_FIND: begin
							cand_d = '0;
							phase_d = PH_ZERO;
							state_d = S_BOUND;
						end
						FN_BIND: begin
							if (cnt_q >= CNT_MAX) begin
								res_status_d = ST_FULL;
							end else begin
								req.we = 1'b1;
								req.waddr = cnt_q[IDX_W-1:0];
								req.wdata.start = offset;
								req.wdata.len = size;
								cnt_d = cnt_q + CNT_W'(1);
								total_d = total_q + TOTAL_W'(size);
							end
						end
						FN_FREE: begin
							if (cnt_q == '0) begin
								res_status_d = ST_NOMATCH;
							end else begin
								req.raddr = '0;
								sidx_d = '0;
								state_d = S_FSCAN;
							end
						end
						default: begin
							res_status_d = ST_OK;
						end
					endcase
				end
			end
			S_BOUND: begin
				pos_d = cand_q[DATA_W-1:0];
				end_d = end_sum[DATA_W-1:0];
				if (end_sum < END_W'(chunk_size)) begin
					if (cnt_q == '0) begin
						res_off_d = cand_q[DATA_W-1:0];
						state_d = S_RESULT;
					end else begin
						req.raddr = '0;
						sidx_d = '0;
						state_d = S_SCAN;
					end
				end else begin
					state_d = S_NEXT;
				end
			end
			S_SCAN: begin
				// rd_data holds entry sidx_q; fetch the next one alongside
				if (hit) begin
					state_d = S_NEXT;
				end else if (scan_last) begin
					res_off_d = pos_q;
					state_d = S_RESULT;
				end else begin
					req.raddr = sidx_q + IDX_W'(1);
					sidx_d = sidx_q + IDX_W'(1);
				end
			end
			S_NEXT: begin
				state_d = S_CALC;
				case (phase_q)
					PH_ZERO: begin
						if (cnt_q == '0) begin
							res_status_d = ST_NOSPACE;
							state_d = S_RESULT;
						end else begin
							req.raddr = cnt_m1[IDX_W-1:0];
							phase_d = PH_LAST;
						end
					end
					PH_LAST: begin
						req.raddr = '0;
						cidx_d = '0;
						phase_d = PH_EACH;
					end
					default: begin
						if (cand_last) begin
							res_status_d = ST_NOSPACE;
							state_d = S_RESULT;
						end else begin
							req.raddr = cidx_q + IDX_W'(1);
							cidx_d = cidx_q + IDX_W'(1);
						end
					end
				endcase
			end
			S_CALC: begin
				cand_d = CAND_W'(rd_data.start) + CAND_W'(rd_data.len) + GAP_BYTES;
				state_d = S_BOUND;
			end
			S_FSCAN: begin
				if (match) begin
					cnt_d = cnt_m1;
					total_d = total_q - TOTAL_W'(size_q);
					res_status_d = ST_OK;
					if (scan_last) begin
						state_d = S_RESULT;
					end else begin
						req.raddr = sidx_q + IDX_W'(1);
						state_d = S_SHIFT;
					end
				end else if (scan_last) begin
					res_status_d = ST_NOMATCH;
					state_d = S_RESULT;
				end else begin
					req.raddr = sidx_q + IDX_W'(1);
					sidx_d = sidx_q + IDX_W'(1);
				end
			end
			S_SHIFT: begin
				// rd_data holds entry sidx_q + 1; move it down one slot
				req.we = 1'b1;
				req.waddr = sidx_q;
				req.wdata = rd_data;
				if (shift_last) begin
					state_d = S_RESULT;
				end else begin
					req.raddr = sidx_q + IDX_W'(2);
					sidx_d = sidx_q + IDX_W'(1);
				end
			end
			S_RESULT: begin
				if (!out_valid_q || !out_stall) begin
					out_valid_d = 1'b1;
					out_status_d = res_status_q;
					out_off_d = (res_status_q == ST_OK) ? res_off_q : '0;
					out_total_d = total_q;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_ZERO;
			cnt_q <= '0;
			total_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			cnt_q <= cnt_d;
			total_q <= total_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		size_q <= size_d;
		offset_q <= offset_d;
		cand_q <= cand_d;
		pos_q <= pos_d;
		end_q <= end_d;
		cidx_q <= cidx_d;
		sidx_q <= sidx_d;
		res_status_q <= res_status_d;
		res_off_q <= res_off_d;
		out_status_q <= out_status_d;
		out_off_q <= out_off_d;
		out_total_q <= out_total_d;
	end

	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign offset_found = out_off_q;
	assign total_allocated = out_total_q;

endmodule

/* rtl/first_fit_range_allocator.sv */
`timescale 1ns / 1ps
// First-fit range allocator: keeps an ordered table of up to MAX_ENTRIES (64) bound
// (offset, size) ranges in one single-port-read table and answers one transaction
// at a time. A free scans the table for the matching entry, then moves each later
// entry down one slot. A find tries offset zero, the slot past the last entry,
// then the slot past each entry; each candidate is checked against the live
// entries one at a time, since the single table read port feeds one overlap
// compare unit. The result sits in an output register, so the next transaction
// is taken while it waits.
module first_fit_range_allocator
	import ffra_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [DATA_W-1:0] cfg_wr_data,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] func,
	input logic [DATA_W-1:0] size,
	input logic [DATA_W-1:0] offset,
	output logic out_valid,
	input logic out_stall,
	output logic [1:0] status,
	output logic [DATA_W-1:0] offset_found,
	output logic [TOTAL_W-1:0] total_allocated
);

	logic [DATA_W-1:0] chunk_size_q;
	tbl_req_t req;
	entry_t rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_size_q <= CHUNK_RESET;
		end else if (cfg_wr_en) begin
			chunk_size_q <= cfg_wr_data;
		end
	end

	ffra_table u_table (
		.clk(clk),
		.req(req),
		.rd_data(rd_data)
	);

	ffra_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.size(size),
		.offset(offset),
		.chunk_size(chunk_size_q),
		.req(req),
		.rd_data(rd_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.offset_found(offset_found),
		.total_allocated(total_allocated)
	);

endmodule

/* rtl/ffra_checker.sv */
`timescale 1ns / 1ps
`include "first_fit_range_allocator_defines.svh"
module ffra_checker
	import ffra_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [1:0] status,
	input logic [DATA_W-1:0] offset_found,
	input logic [TOTAL_W-1:0] total_allocated
);

	`FFRA_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	`FFRA_ASSERT_IMP(a_fail_zero_offset, out_valid && status != ST_OK, offset_found == '0)
	`FFRA_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
	`FFRA_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(status) && $stable(offset_found))
	`FFRA_ASSERT_NXT(a_total_stable, out_valid && out_stall, $stable(total_allocated))

endmodule

bind first_fit_range_allocator ffra_checker u_ffra_checker (.*);
